[hw/rtl/lcdw_pkg.sv]
package lcdw_pkg;

  localparam logic [7:0] CMD_SW_RESET   = 8'h01;
  localparam logic [7:0] CMD_SLEEP_OUT  = 8'h11;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h29;
  localparam logic [7:0] CMD_COL_SET    = 8'h2a;
  localparam logic [7:0] CMD_PAGE_SET   = 8'h2b;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2c;
  localparam logic [7:0] CMD_MADCTL     = 8'h36;
  localparam logic [7:0] CMD_PIX_FMT    = 8'h3a;
  localparam logic [7:0] CMD_FRAME_CTRL = 8'hb1;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'hb7;
  localparam logic [7:0] CMD_PWR_CTRL1  = 8'hc0;
  localparam logic [7:0] CMD_PWR_CTRL2  = 8'hc1;
  localparam logic [7:0] CMD_VCOM_CTRL1 = 8'hc5;
  localparam logic [7:0] CMD_VCOM_CTRL2 = 8'hc7;

  localparam int unsigned CURSOR_W    = 17;
  localparam int unsigned WIN_W       = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_COL_START,
    OP_COL_END,
    OP_ROW_START,
    OP_ROW_END,
    OP_MEM_START,
    OP_PIXEL
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } lcdw_op_t;

endpackage

[hw/rtl/lcd_controller_window_write.sv]
// Display controller window write: takes 8-bit command/data bus beats and
// turns memory-write pixel data into framebuffer byte writes with a 17-bit
// pixel index. One beat per cycle is accepted sustained while the queue is
// not full. A front stage tracks the active command and parameter count,
// a two-entry queue decouples it from the back stage, which pops each
// entry, updates the window and cursor and computes row * PANEL_WIDTH +
// col into a registered output. Off-panel and out-of-window bytes give no
// beat on the output.
module lcd_controller_window_write
  import lcdw_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 320,
  parameter int unsigned PANEL_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  bus_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] pixel_index_o,
  output logic        high_half_o,
  output logic [7:0]  pixel_byte_o
);

  logic     push, pop, empty, full;
  lcdw_op_t push_op, pop_op;

  lcdw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .bus_byte_i (bus_byte_i),
    .full_i     (full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  lcdw_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .pop_op_o  (pop_op),
    .empty_o   (empty),
    .full_o    (full)
  );

  lcdw_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .op_i          (pop_op),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .high_half_o   (high_half_o),
    .pixel_byte_o  (pixel_byte_o)
  );

endmodule

[hw/rtl/lcdw_front.sv]
module lcdw_front
  import lcdw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     func_i,
  input  logic [7:0] bus_byte_i,
  input  logic     full_i,
  output logic     push_o,
  output lcdw_op_t push_op_o
);

  logic [7:0] active_cmd_q, active_cmd_d;
  logic [2:0] params_q, params_d;
  logic       accept;
  logic [2:0] params_dec;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign params_dec = (params_q != 3'd0) ? params_q - 3'd1 : 3'd0;

  always_comb begin
    active_cmd_d        = active_cmd_q;
    params_d            = params_q;
    push_o              = 1'b0;
    push_op_o.op        = OP_PIXEL;
    push_op_o.data      = bus_byte_i;
    if (accept) begin
      if (!func_i) begin
        active_cmd_d = bus_byte_i;
        case (bus_byte_i) inside
          CMD_SW_RESET, CMD_SLEEP_OUT, CMD_DISP_OFF, CMD_DISP_ON: params_d = 3'd0;
          CMD_PWR_CTRL1, CMD_PWR_CTRL2, CMD_VCOM_CTRL2, CMD_MADCTL, CMD_PIX_FMT,
          CMD_ENTRY_MODE: params_d = 3'd1;
          CMD_VCOM_CTRL1, CMD_FRAME_CTRL: params_d = 3'd2;
          CMD_COL_SET, CMD_PAGE_SET: params_d = 3'd4;
          CMD_MEM_WRITE: begin
            params_d     = 3'd0;
            push_o       = 1'b1;
            push_op_o.op = OP_MEM_START;
          end
          default: params_d = params_q;
        endcase
      end else begin
        case (active_cmd_q)
          CMD_COL_SET: begin
            push_o       = 1'b1;
            push_op_o.op = (params_q > 3'd2) ? OP_COL_START : OP_COL_END;
            params_d     = params_dec;
          end
          CMD_PAGE_SET: begin
            push_o       = 1'b1;
            push_op_o.op = (params_q > 3'd2) ? OP_ROW_START : OP_ROW_END;
            params_d     = params_dec;
          end
          CMD_MEM_WRITE: begin
            push_o       = 1'b1;
            push_op_o.op = OP_PIXEL;
          end
          default: push_o = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_cmd_q <= '0;
      params_q     <= '0;
    end else begin
      active_cmd_q <= active_cmd_d;
      params_q     <= params_d;
    end
  end

endmodule

[hw/rtl/lcdw_queue.sv]
module lcdw_queue
  import lcdw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lcdw_op_t push_op_i,
  input  logic     pop_i,
  output lcdw_op_t pop_op_o,
  output logic     empty_o,
  output logic     full_o
);

  lcdw_op_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign empty_o  = (count_q == '0);
  assign full_o   = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && !empty_o;
  assign pop_op_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

[hw/rtl/lcdw_back.sv]
module lcdw_back
  import lcdw_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 320,
  parameter int unsigned PANEL_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  lcdw_op_t    op_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [16:0] pixel_index_o,
  output logic        high_half_o,
  output logic [7:0]  pixel_byte_o
);

  logic [WIN_W-1:0]    col_start_q, col_start_d, col_end_q, col_end_d;
  logic [WIN_W-1:0]    row_start_q, row_start_d, row_end_q, row_end_d;
  logic [CURSOR_W-1:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic                phase_q, phase_d;
  logic                out_valid_q, out_valid_d;
  logic [16:0]         index_q, index_d;
  logic                high_q, high_d;
  logic [7:0]          byte_q, byte_d;

  logic [CURSOR_W-1:0] col_w, row_w;
  logic                wrap, in_win, on_panel;

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  assign wrap     = cur_col_q > {1'b0, col_end_q};
  assign col_w    = wrap ? {1'b0, col_start_q} : cur_col_q;
  assign row_w    = wrap ? cur_row_q + 1'b1 : cur_row_q;
  assign in_win   = row_w <= {1'b0, row_end_q};
  assign on_panel = (col_w < CURSOR_W'(PANEL_WIDTH)) && (row_w < CURSOR_W'(PANEL_HEIGHT));

  always_comb begin
    col_start_d = col_start_q;
    col_end_d   = col_end_q;
    row_start_d = row_start_q;
    row_end_d   = row_end_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && !out_ready_i;
    index_d     = index_q;
    high_d      = high_q;
    byte_d      = byte_q;
    if (pop_o) begin
      case (op_i.op)
        OP_COL_START: col_start_d = {col_start_q[7:0], op_i.data};
        OP_COL_END:   col_end_d   = {col_end_q[7:0], op_i.data};
        OP_ROW_START: row_start_d = {row_start_q[7:0], op_i.data};
        OP_ROW_END:   row_end_d   = {row_end_q[7:0], op_i.data};
        OP_MEM_START: begin
          cur_col_d = {1'b0, col_start_q};
          cur_row_d = {1'b0, row_start_q};
          phase_d   = 1'b0;
        end
        OP_PIXEL: begin
          cur_col_d = col_w;
          cur_row_d = row_w;
          if (in_win) begin
            phase_d = !phase_q;
            if (phase_q) begin
              cur_col_d = col_w + 1'b1;
            end
            if (on_panel) begin
              out_valid_d = 1'b1;
              index_d     = 17'(row_w * CURSOR_W'(PANEL_WIDTH)) + col_w;
              high_d      = !phase_q;
              byte_d      = op_i.data;
            end
          end
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_start_q <= '0;
      col_end_q   <= '0;
      row_start_q <= '0;
      row_end_q   <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_start_q <= col_start_d;
      col_end_q   <= col_end_d;
      row_start_q <= row_start_d;
      row_end_q   <= row_end_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    index_q <= index_d;
    high_q  <= high_d;
    byte_q  <= byte_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = index_q;
  assign high_half_o   = high_q;
  assign pixel_byte_o  = byte_q;

  a_mem_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && op_i.op == OP_MEM_START |=> !phase_q)
    else $error("memory write did not restart on a high byte");

  a_index_on_panel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> 32'(index_q) < 32'(PANEL_WIDTH * PANEL_HEIGHT))
    else $error("pixel index beyond panel");

  a_no_pop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !pop_o)
    else $error("op executed while result stalled");

endmodule

[test/lcd_controller_window_write_tb.sv]
`timescale 1ns / 100ps

module lcd_controller_window_write_tb;
  import lcdw_pkg::*;

  localparam int unsigned PANEL_WIDTH  = 320;
  localparam int unsigned PANEL_HEIGHT = 240;
  localparam logic FUNC_CMD  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam logic [7:0] KNOWN_CMDS [15] = '{
    CMD_SW_RESET, CMD_SLEEP_OUT, CMD_DISP_OFF, CMD_DISP_ON, CMD_COL_SET,
    CMD_PAGE_SET, CMD_MEM_WRITE, CMD_MADCTL, CMD_PIX_FMT, CMD_FRAME_CTRL,
    CMD_ENTRY_MODE, CMD_PWR_CTRL1, CMD_PWR_CTRL2, CMD_VCOM_CTRL1, CMD_VCOM_CTRL2
  };

  typedef struct {
    logic [16:0] idx;
    logic        hi;
    logic [7:0]  data;
  } pixel_write_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        func_i;
  logic [7:0]  bus_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [16:0] pixel_index_o;
  logic        high_half_o;
  logic [7:0]  pixel_byte_o;

  // predictor state
  logic [7:0]  cmd_latched;
  logic [2:0]  params_left;
  logic [15:0] col_lo, col_hi, row_lo, row_hi;
  logic [16:0] cur_col, cur_row;
  logic        second_byte;

  pixel_write_t pending_writes[$];
  int unsigned  beats_done;
  int unsigned  error_count;
  int unsigned  out_stall;
  bit           no_gaps;

  lcd_controller_window_write #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .bus_byte_i   (bus_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_index_o(pixel_index_o),
    .high_half_o  (high_half_o),
    .pixel_byte_o (pixel_byte_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic predict_beat(input logic f, input logic [7:0] b, output bit counted);
    pixel_write_t w;
    logic [31:0]  flat;
    counted = 1'b1;
    if (f == FUNC_CMD) begin
      cmd_latched = b;
      case (b)
        CMD_SW_RESET, CMD_SLEEP_OUT, CMD_DISP_OFF, CMD_DISP_ON: params_left = 3'd0;
        CMD_PWR_CTRL1, CMD_PWR_CTRL2, CMD_VCOM_CTRL2, CMD_MADCTL, CMD_PIX_FMT,
        CMD_ENTRY_MODE: params_left = 3'd1;
        CMD_VCOM_CTRL1, CMD_FRAME_CTRL: params_left = 3'd2;
        CMD_COL_SET, CMD_PAGE_SET: params_left = 3'd4;
        CMD_MEM_WRITE: begin
          cur_col     = {1'b0, col_lo};
          cur_row     = {1'b0, row_lo};
          second_byte = 1'b0;
          params_left = 3'd0;
        end
        default: ;
      endcase
    end else if (cmd_latched == CMD_COL_SET || cmd_latched == CMD_PAGE_SET) begin
      if (params_left > 3'd2) begin
        if (cmd_latched == CMD_COL_SET) col_lo = {col_lo[7:0], b};
        else row_lo = {row_lo[7:0], b};
      end else begin
        if (cmd_latched == CMD_COL_SET) col_hi = {col_hi[7:0], b};
        else row_hi = {row_hi[7:0], b};
      end
      if (params_left != 3'd0) params_left = params_left - 3'd1;
    end else if (cmd_latched == CMD_MEM_WRITE) begin
      if (cur_col > col_hi) begin
        cur_col = {1'b0, col_lo};
        cur_row = cur_row + 17'd1;
      end
      if (cur_row <= row_hi) begin
        if (cur_col < PANEL_WIDTH && cur_row < PANEL_HEIGHT) begin
          flat   = cur_row * PANEL_WIDTH + cur_col;
          w.idx  = flat[16:0];
          w.hi   = ~second_byte;
          w.data = b;
          pending_writes.push_back(w);
        end
        if (second_byte) begin
          second_byte = 1'b0;
          cur_col     = cur_col + 17'd1;
        end else begin
          second_byte = 1'b1;
        end
      end
    end else begin
      counted = 1'b0;
    end
  endtask

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_beat(input logic f, input logic [7:0] b);
    int unsigned gap;
    bit          counted;
    in_valid_i <= 1'b1;
    func_i     <= f;
    bus_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(f, b, counted);
    if (counted) beats_done++;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_writes();
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  // address set command with a given number of parameter bytes
  task automatic send_window(input logic [7:0] cmd, input logic [15:0] lo,
                             input logic [15:0] hi, input int unsigned nbytes);
    logic [7:0] seq [4];
    seq = '{lo[15:8], lo[7:0], hi[15:8], hi[7:0]};
    send_beat(FUNC_CMD, cmd);
    for (int unsigned i = 0; i < nbytes; i++)
      send_beat(FUNC_DATA, (i < 4) ? seq[i] : 8'($urandom));
  endtask

  task automatic pick_span(input int unsigned extent, output logic [15:0] lo,
                           output logic [15:0] hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      lo = 16'($urandom_range(0, extent - 1));
      hi = lo + 16'($urandom_range(0, 5));
    end else if (r < 85) begin
      lo = 16'(extent - $urandom_range(1, 3));
      hi = lo + 16'($urandom_range(1, 5));
    end else if (r < 92) begin
      lo = 16'($urandom_range(0, extent - 1));
      hi = lo - 16'($urandom_range(1, 3));
    end else if (r < 96) begin
      lo = 16'hffff - 16'($urandom_range(0, 2));
      hi = 16'hffff;
    end else begin
      lo = 16'($urandom);
      hi = 16'($urandom);
    end
  endtask

  task automatic send_pixels(input int unsigned nbytes);
    repeat (nbytes) send_beat(FUNC_DATA, 8'($urandom));
  endtask

  task automatic send_frame(input int unsigned col_bytes, input int unsigned row_bytes);
    logic [15:0] lo, hi;
    pick_span(PANEL_WIDTH, lo, hi);
    send_window(CMD_COL_SET, lo, hi, col_bytes);
    pick_span(PANEL_HEIGHT, lo, hi);
    send_window(CMD_PAGE_SET, lo, hi, row_bytes);
    send_beat(FUNC_CMD, CMD_MEM_WRITE);
    send_pixels(($urandom_range(0, 99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 80));
  endtask

  task automatic send_setup_command();
    logic [7:0] cmd;
    cmd = ($urandom_range(0, 3) != 0) ? KNOWN_CMDS[$urandom_range(0, 14)] : 8'($urandom);
    send_beat(FUNC_CMD, cmd);
    repeat ($urandom_range(0, 3)) send_beat(FUNC_DATA, 8'($urandom));
  endtask

  task automatic send_broken_frame();
    case ($urandom_range(0, 2))
      0: send_frame($urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(5, 7),
                    $urandom_range(1, 7));
      1: begin
        send_beat(FUNC_CMD, CMD_MEM_WRITE);
        send_pixels($urandom_range(1, 5));
        send_setup_command();
        send_pixels($urandom_range(1, 4));
      end
      default: begin
        send_beat(FUNC_CMD, CMD_MEM_WRITE);
        send_pixels($urandom_range(1, 7));
        send_beat(FUNC_CMD, CMD_MEM_WRITE);
        send_pixels($urandom_range(1, 7));
      end
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_beat(1'($urandom), 8'($urandom));
  endtask

  task automatic test_window_edges();
    send_beat(FUNC_DATA, 8'hff);  // no command latched yet
    send_window(CMD_COL_SET, 16'd318, 16'd321, 4);
    // extra parameter byte shifts into the page end register
    send_window(CMD_PAGE_SET, 16'd239, 16'd0, 5);
    send_beat(FUNC_CMD, CMD_MEM_WRITE);
    send_beat(FUNC_DATA, 8'hff);
    send_beat(FUNC_DATA, 8'h00);
    send_beat(FUNC_DATA, 8'h12);
    send_beat(FUNC_DATA, 8'h34);
    send_beat(FUNC_DATA, 8'h56);  // first off-panel column
    send_beat(FUNC_CMD, CMD_MEM_WRITE);  // restart mid-pixel
    send_beat(FUNC_DATA, 8'haa);
    send_beat(FUNC_DATA, 8'h55);
    send_beat(FUNC_CMD, CMD_VCOM_CTRL1);
    send_beat(FUNC_DATA, 8'h80);
    send_beat(FUNC_CMD, 8'hff);
    send_beat(FUNC_DATA, 8'h01);
    drain_writes();
  endtask

  task automatic test_random_traffic(input int unsigned beats);
    int unsigned goal;
    int unsigned r;
    goal = beats_done + beats;
    while (beats_done < goal) begin
      r = $urandom_range(0, 99);
      if (r < 65) send_frame(4, 4);
      else if (r < 80) send_setup_command();
      else if (r < 90) send_broken_frame();
      else send_noise();
    end
  endtask

  task automatic test_back_to_back(input int unsigned beats);
    no_gaps = 1'b1;
    test_random_traffic(beats);
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_then_resume(input int unsigned beats);
    drain_writes();
    test_random_traffic(beats);
  endtask

  always @(posedge clk_i) begin
    if (no_gaps) begin
      out_stall = 0;
      out_ready_i <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pixel_write_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_writes.size() == 0) begin
        error_count++;
        $display("%0t: unexpected write: expected none, got idx %0d hi %b byte %h",
                 $time, pixel_index_o, high_half_o, pixel_byte_o);
      end else begin
        w = pending_writes.pop_front();
        if (pixel_index_o !== w.idx) begin
          error_count++;
          $display("%0t: pixel_index expected %0d got %0d", $time, w.idx, pixel_index_o);
        end
        if (high_half_o !== w.hi) begin
          error_count++;
          $display("%0t: high_half expected %b got %b", $time, w.hi, high_half_o);
        end
        if (pixel_byte_o !== w.data) begin
          error_count++;
          $display("%0t: pixel_byte expected %h got %h", $time, w.data, pixel_byte_o);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("** lcd_controller_window_write: FAILED **");
    $finish;
  end

  initial begin
    cmd_latched = '0;
    params_left = '0;
    col_lo      = '0;
    col_hi      = '0;
    row_lo      = '0;
    row_hi      = '0;
    cur_col     = '0;
    cur_row     = '0;
    second_byte = 1'b0;
    beats_done  = 0;
    error_count = 0;
    out_stall   = 0;
    no_gaps     = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    func_i      <= FUNC_CMD;
    bus_byte_i  <= 8'h00;
    out_ready_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_window_edges();
    test_random_traffic(600);
    test_back_to_back(300);
    test_pause_then_resume(600);
    drain_writes();

    if (error_count == 0) begin
      $display("** lcd_controller_window_write: PASSED **");
    end else begin
      $display("** lcd_controller_window_write: FAILED **");
    end
    $finish;
  end

endmodule
